// ----- hdl/sme_pkg.sv -----
// types, codes and constants shared by the stack machine executor files
`timescale 1ns / 1ps

package sme_pkg;

  localparam int WORD_W      = 32;
  localparam int OPCODE_W    = 4;
  localparam int PTR_OUT_W   = 12;
  localparam int DEPTH_OUT_W = 12;
  localparam int PLEN_W      = 12;
  localparam int STEP_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int STACK_DEPTH_DEF = 2048;
  localparam int MEM_DEPTH_DEF   = 1024;
  localparam int PROG_DEPTH_DEF  = 2048;

  localparam logic [PLEN_W-1:0] PLEN_RESET      = PLEN_W'(0);
  localparam logic [STEP_W-1:0] MAX_STEPS_RESET = STEP_W'(2000);

  typedef enum logic [OPCODE_W-1:0] {
    OP_RET = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_CMP = 4'd3,
    OP_LD  = 4'd4,
    OP_ST  = 4'd5,
    OP_LDC = 4'd6,
    OP_JMP = 4'd7,
    OP_BR  = 4'd8
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN     = 3'd0,
    ST_RET     = 3'd1,
    ST_END     = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_UNDER   = 3'd4,
    ST_OVER    = 3'd5,
    ST_BADADDR = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROGRAM_LENGTH = 1'd0,
    CFG_MAX_STEPS      = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STK_NONE    = 2'd0,
    STK_PUSH    = 2'd1,
    STK_POP     = 2'd2,
    STK_REPLACE = 2'd3
  } stk_op_e;

  typedef struct packed {
    stk_op_e           op;
    logic [WORD_W-1:0] value;
  } stk_cmd_t;

endpackage

// ----- hdl/sme_if.sv -----
// valid/ready channel interfaces for instructions and results
`timescale 1ns / 1ps

interface sme_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sme_pkg::OPCODE_W-1:0]         opcode;
  logic signed [sme_pkg::WORD_W-1:0]    argument;

  modport source (output valid, output opcode, output argument, input ready);
  modport sink   (input valid, input opcode, input argument, output ready);
endinterface

interface sme_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sme_pkg::PTR_OUT_W-1:0]        next_pointer;
  logic [sme_pkg::STATUS_W-1:0]         status;
  logic signed [sme_pkg::WORD_W-1:0]    top_value;
  logic [sme_pkg::DEPTH_OUT_W-1:0]      stack_depth;

  modport source (output valid, output next_pointer, output status, output top_value,
                  output stack_depth, input ready);
  modport sink   (input valid, input next_pointer, input status, input top_value,
                  input stack_depth, output ready);
endinterface

// ----- hdl/stack_machine_executor_top.sv -----
// stack machine executor: instruction register, execute logic and result register
`timescale 1ns / 1ps
//
// usage
//   in_i carries one instruction per transfer (opcode and argument fetched at
//   the last reported next_pointer). out_o returns one result per instruction:
//   next pointer, status, top of stack and stack depth after the step.
//   cfg_we_i/cfg_index_i/cfg_data_i write program_length (index 0) and
//   max_steps (index 1); write them only while no instruction is in flight.
// timing
//   an accepted instruction waits in the instruction register until the result
//   register is free or out_o.ready is high, then executes and its result is
//   registered, raising out_o.valid. one instruction per cycle is sustained
//   while out_o.ready is high; the instruction register, data memory read port,
//   top-two stack registers and prefetched third stack entry allow this.
// reset
//   control state clears at once; the data memory is then zeroed one word a
//   cycle over all MEM_DEPTH words (1024 by default) with in_i.ready held low.
// stall
//   when out_o.ready is low the result holds, the pending instruction waits
//   in the instruction register and in_i.ready drops until the result leaves.
//
module stack_machine_executor_top #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int MEM_DEPTH   = sme_pkg::MEM_DEPTH_DEF,
  parameter int PROG_DEPTH  = sme_pkg::PROG_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sme_in_if.sink                            in_i,
  sme_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [sme_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sme_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int WordW   = sme_pkg::WORD_W;
  localparam int DepthW  = $clog2(STACK_DEPTH + 1);
  localparam int MemAw   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IpW     = ($clog2(PROG_DEPTH + 1) > sme_pkg::PLEN_W) ?
                           $clog2(PROG_DEPTH + 1) : sme_pkg::PLEN_W;
  localparam int StepW   = sme_pkg::STEP_W;

  // configuration
  logic [sme_pkg::PLEN_W-1:0] plen_q;
  logic [StepW-1:0]           max_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= sme_pkg::PLEN_RESET;
      max_steps_q <= sme_pkg::MAX_STEPS_RESET;
    end else if (cfg_we_i) begin
      case (sme_pkg::cfg_reg_e'(cfg_index_i))
        sme_pkg::CFG_PROGRAM_LENGTH: plen_q      <= cfg_data_i[sme_pkg::PLEN_W-1:0];
        sme_pkg::CFG_MAX_STEPS:      max_steps_q <= cfg_data_i[StepW-1:0];
        default:                     plen_q      <= plen_q;
      endcase
    end
  end

  // instruction register
  logic                    s1_valid_q;
  logic [sme_pkg::OPCODE_W-1:0] s1_op_q;
  logic [WordW-1:0]        s1_arg_q;
  logic                    exec;
  logic                    in_xfer;
  logic                    out_valid_q;
  logic                    dm_busy;

  assign exec        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !dm_busy && (!s1_valid_q || exec);
  assign in_xfer     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (exec) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q  <= in_i.opcode;
      s1_arg_q <= in_i.argument;
    end
  end

  // architectural state
  logic [IpW-1:0]     ip_q, ip_d;
  logic [StepW-1:0]   step_q, step_d;
  sme_pkg::status_e   status_q, status_d;

  // stack and data memory
  sme_pkg::stk_cmd_t  stk_cmd;
  logic [DepthW-1:0]  depth;
  logic [WordW-1:0]   top, second;
  logic               dm_we;
  logic [WordW-1:0]   dm_rdata;
  logic [WordW-1:0]   in_arg_u;

  assign in_arg_u = in_i.argument;

  sme_stack #(
    .StackDepth (STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (stk_cmd),
    .depth_o  (depth),
    .top_o    (top),
    .second_o (second)
  );

  sme_dmem #(
    .MemDepth (MEM_DEPTH)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_arg_u[MemAw-1:0]),
    .rd_data_o (dm_rdata),
    .wr_en_i   (dm_we),
    .wr_addr_i (s1_arg_q[MemAw-1:0]),
    .wr_data_i (top),
    .busy_o    (dm_busy)
  );

  // execute
  logic               mem_bad, jmp_bad, d_ge1, d_ge2, full;
  logic [WordW-1:0]   alu;
  logic [IpW-1:0]     ip_next;
  sme_pkg::status_e   err;
  logic               is_ret;
  logic [DepthW-1:0]  depth_after;
  logic [WordW-1:0]   top_after;

  assign mem_bad = s1_arg_q[WordW-1] || (s1_arg_q >= WordW'(MEM_DEPTH));
  assign jmp_bad = s1_arg_q[WordW-1] || (s1_arg_q > WordW'(PROG_DEPTH));
  assign d_ge1   = (depth != '0);
  assign d_ge2   = (depth >= DepthW'(2));
  assign full    = (depth == DepthW'(STACK_DEPTH));

  always_comb begin
    case (sme_pkg::opcode_e'(s1_op_q))
      sme_pkg::OP_ADD: alu = second + top;
      sme_pkg::OP_SUB: alu = top - second;
      default: begin
        if ($signed(second) < $signed(top)) begin
          alu = WordW'(1);
        end else if ($signed(second) > $signed(top)) begin
          alu = '1;
        end else begin
          alu = '0;
        end
      end
    endcase
  end

  always_comb begin
    ip_d         = ip_q;
    step_d       = step_q;
    status_d     = status_q;
    stk_cmd.op   = sme_pkg::STK_NONE;
    stk_cmd.value = '0;
    dm_we        = 1'b0;
    err          = sme_pkg::ST_RUN;
    is_ret       = 1'b0;
    ip_next      = ip_q + IpW'(1);
    if (exec && status_q == sme_pkg::ST_RUN) begin
      if (ip_q >= IpW'(plen_q)) begin
        status_d = sme_pkg::ST_END;
      end else begin
        case (sme_pkg::opcode_e'(s1_op_q))
          sme_pkg::OP_RET: begin
            is_ret  = 1'b1;
            ip_next = ip_q;
          end
          sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: begin
            if (!d_ge2) begin
              err = sme_pkg::ST_UNDER;
            end else begin
              stk_cmd.op    = sme_pkg::STK_REPLACE;
              stk_cmd.value = alu;
            end
          end
          sme_pkg::OP_LD: begin
            if (mem_bad) begin
              err = sme_pkg::ST_BADADDR;
            end else if (full) begin
              err = sme_pkg::ST_OVER;
            end else begin
              stk_cmd.op    = sme_pkg::STK_PUSH;
              stk_cmd.value = dm_rdata;
            end
          end
          sme_pkg::OP_ST: begin
            if (!d_ge1) begin
              err = sme_pkg::ST_UNDER;
            end else if (mem_bad) begin
              err = sme_pkg::ST_BADADDR;
            end else begin
              stk_cmd.op = sme_pkg::STK_POP;
              dm_we      = 1'b1;
            end
          end
          sme_pkg::OP_LDC: begin
            if (full) begin
              err = sme_pkg::ST_OVER;
            end else begin
              stk_cmd.op    = sme_pkg::STK_PUSH;
              stk_cmd.value = s1_arg_q;
            end
          end
          sme_pkg::OP_JMP: begin
            if (jmp_bad) begin
              err = sme_pkg::ST_BADADDR;
            end else begin
              ip_next = s1_arg_q[IpW-1:0];
            end
          end
          sme_pkg::OP_BR: begin
            if (!d_ge1) begin
              err = sme_pkg::ST_UNDER;
            end else if (top != '0) begin
              if (jmp_bad) begin
                err = sme_pkg::ST_BADADDR;
              end else begin
                ip_next = s1_arg_q[IpW-1:0];
              end
            end
          end
          default: begin
            // unknown opcode only counts the step
            ip_next = ip_q;
          end
        endcase

        if (err != sme_pkg::ST_RUN) begin
          status_d = err;
        end else begin
          step_d = (step_q != '1) ? step_q + StepW'(1) : step_q;
          ip_d   = ip_next;
          if (is_ret) begin
            status_d = sme_pkg::ST_RET;
          end else if (step_q >= max_steps_q) begin
            status_d = sme_pkg::ST_LIMIT;
          end else if (ip_next >= IpW'(plen_q)) begin
            status_d = sme_pkg::ST_END;
          end
        end
      end
    end
  end

  always_comb begin
    case (stk_cmd.op)
      sme_pkg::STK_PUSH: begin
        depth_after = depth + DepthW'(1);
        top_after   = stk_cmd.value;
      end
      sme_pkg::STK_POP: begin
        depth_after = depth - DepthW'(1);
        top_after   = second;
      end
      sme_pkg::STK_REPLACE: begin
        depth_after = depth - DepthW'(1);
        top_after   = stk_cmd.value;
      end
      default: begin
        depth_after = depth;
        top_after   = top;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q     <= '0;
      step_q   <= '0;
      status_q <= sme_pkg::ST_RUN;
    end else begin
      ip_q     <= ip_d;
      step_q   <= step_d;
      status_q <= status_d;
    end
  end

  // result register
  logic [sme_pkg::PTR_OUT_W-1:0]   res_ptr_q;
  logic [sme_pkg::STATUS_W-1:0]    res_status_q;
  logic [WordW-1:0]                res_top_q;
  logic [sme_pkg::DEPTH_OUT_W-1:0] res_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_ptr_q    <= sme_pkg::PTR_OUT_W'(ip_d);
      res_status_q <= status_d;
      res_top_q    <= (depth_after != '0) ? top_after : '0;
      res_depth_q  <= sme_pkg::DEPTH_OUT_W'(depth_after);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_pointer = res_ptr_q;
  assign out_o.status       = res_status_q;
  assign out_o.top_value    = res_top_q;
  assign out_o.stack_depth  = res_depth_q;

  a_halt_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != sme_pkg::ST_RUN |=> status_q == $past(status_q))
    else $error("halt status changed");

  a_ip_only_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> ip_q == $past(ip_q) && step_q == $past(step_q))
    else $error("pointer or step count moved without an instruction");

  a_step_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> step_q >= $past(step_q))
    else $error("step count decreased");

  a_no_mem_write_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_we |-> status_q == sme_pkg::ST_RUN && s1_valid_q)
    else $error("store retired while halted or idle");

endmodule

// ----- hdl/sme_stack.sv -----
// operand stack: top two entries in registers, the rest in a ram with a prefetched third entry
`timescale 1ns / 1ps

module sme_stack #(
  parameter int StackDepth = sme_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sme_pkg::stk_cmd_t             cmd_i,
  output logic [$clog2(StackDepth+1)-1:0] depth_o,
  output logic [sme_pkg::WORD_W-1:0]    top_o,
  output logic [sme_pkg::WORD_W-1:0]    second_o
);

  localparam int DepthW = $clog2(StackDepth + 1);
  localparam int AddrW  = $clog2(StackDepth);

  logic [DepthW-1:0] depth_q, depth_d;
  logic [sme_pkg::WORD_W-1:0] top_q, top_d, second_q, second_d;
  logic [sme_pkg::WORD_W-1:0] ram_q [StackDepth];
  logic [sme_pkg::WORD_W-1:0] rdata_q, fwd_data_q, third;
  logic fwd_q;
  logic ram_we;
  logic [DepthW-1:0] waddr_full, raddr_full;
  logic [AddrW-1:0] waddr, raddr;

  assign third = fwd_q ? fwd_data_q : rdata_q;

  assign waddr_full = depth_q - DepthW'(2);
  assign raddr_full = depth_d - DepthW'(3);
  assign waddr      = waddr_full[AddrW-1:0];
  assign raddr      = raddr_full[AddrW-1:0];

  always_comb begin
    depth_d  = depth_q;
    top_d    = top_q;
    second_d = second_q;
    ram_we   = 1'b0;
    case (cmd_i.op)
      sme_pkg::STK_PUSH: begin
        depth_d  = depth_q + DepthW'(1);
        top_d    = cmd_i.value;
        second_d = top_q;
        // second spills to ram once it is no longer among the top two
        ram_we   = (depth_q >= DepthW'(2));
      end
      sme_pkg::STK_POP: begin
        depth_d  = depth_q - DepthW'(1);
        top_d    = second_q;
        second_d = third;
      end
      sme_pkg::STK_REPLACE: begin
        depth_d  = depth_q - DepthW'(1);
        top_d    = cmd_i.value;
        second_d = third;
      end
      default: begin
        depth_d = depth_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      // a spill to the entry being prefetched is taken from the write side
      fwd_q   <= ram_we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    second_q   <= second_d;
    fwd_data_q <= second_q;
    rdata_q    <= ram_q[raddr];
    if (ram_we) begin
      ram_q[waddr] <= second_q;
    end
  end

  assign depth_o  = depth_q;
  assign top_o    = top_q;
  assign second_o = second_q;

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == sme_pkg::STK_PUSH |-> depth_q < DepthW'(StackDepth))
    else $error("push on full stack");

  a_pop_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sme_pkg::STK_POP && depth_q != '0) ||
    (cmd_i.op == sme_pkg::STK_REPLACE && depth_q >= DepthW'(2)) ||
    cmd_i.op == sme_pkg::STK_PUSH || cmd_i.op == sme_pkg::STK_NONE)
    else $error("pop beyond stack contents");

  a_push_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == sme_pkg::STK_PUSH |=>
      depth_q == $past(depth_q) + DepthW'(1) && second_q == $past(top_q))
    else $error("push did not shift the top");

endmodule

// ----- hdl/sme_dmem.sv -----
// data memory with a zeroing pass after reset and a read port registered at instruction transfer
`timescale 1ns / 1ps

module sme_dmem #(
  parameter int MemDepth = sme_pkg::MEM_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [(MemDepth > 1 ? $clog2(MemDepth) : 1)-1:0] rd_addr_i,
  output logic [sme_pkg::WORD_W-1:0]            rd_data_o,
  input  logic                                  wr_en_i,
  input  logic [(MemDepth > 1 ? $clog2(MemDepth) : 1)-1:0] wr_addr_i,
  input  logic [sme_pkg::WORD_W-1:0]            wr_data_i,
  output logic                                  busy_o
);

  localparam int AddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [sme_pkg::WORD_W-1:0] mem_q [MemDepth];
  logic [sme_pkg::WORD_W-1:0] rdata_q, fwd_data_q;
  logic fwd_q;
  logic clearing_q;
  logic [AddrW-1:0] clr_addr_q;
  logic we;
  logic [AddrW-1:0] waddr;
  logic [sme_pkg::WORD_W-1:0] wdata;

  always_comb begin
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = wr_en_i;
      waddr = wr_addr_i;
      wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      fwd_q      <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_addr_q == AddrW'(MemDepth - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (rd_en_i) begin
        // store retiring on the same edge as the read
        fwd_q <= we && (waddr == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= wdata;
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;
  assign busy_o    = clearing_q;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the stack machine executor: predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module testbench;
  import sme_pkg::*;

  typedef struct {
    logic [PTR_OUT_W-1:0]   ptr;
    status_e                status;
    logic [WORD_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
  } step_result_t;

  // what finally stops the machine; the run has a single reset, so one per run
  typedef enum int {
    END_RET,
    END_UNDERFLOW,
    END_OVERFLOW,
    END_BAD_ADDRESS,
    END_STEP_LIMIT,
    END_CUT_PROGRAM,
    END_RUN_OFF
  } ending_e;

  class step_scoreboard;
    logic [WORD_W-1:0] stack_words [STACK_DEPTH_DEF];
    logic [WORD_W-1:0] data_words [MEM_DEPTH_DEF];
    int unsigned       ip;
    int unsigned       depth;
    int unsigned       steps;
    status_e           halt;
    int unsigned       plen;
    int unsigned       max_steps;
    step_result_t      expected_steps[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (stack_words[i]) stack_words[i] = '0;
      foreach (data_words[i]) data_words[i] = '0;
      ip        = 0;
      depth     = 0;
      steps     = 0;
      halt      = ST_RUN;
      plen      = PLEN_RESET;
      max_steps = MAX_STEPS_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_config(cfg_reg_e idx, int unsigned value);
      if (idx == CFG_PROGRAM_LENGTH) plen = value & ((1 << PLEN_W) - 1);
      else max_steps = value & ((1 << STEP_W) - 1);
    endfunction

    function int unsigned pending();
      return expected_steps.size();
    endfunction

    // execute one instruction on the shadow machine and queue its result
    function void note_instr(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] arg);
      int unsigned       nxt;
      int unsigned       d;
      int unsigned       old;
      status_e           fault;
      bit                is_ret;
      longint            sarg;
      logic [WORD_W-1:0] second;
      logic [WORD_W-1:0] top;
      logic [WORD_W-1:0] res;
      step_result_t      r;
      sarg = longint'($signed(arg));
      if (halt == ST_RUN && ip >= plen) halt = ST_END;
      if (halt == ST_RUN) begin
        nxt    = ip + 1;
        d      = depth;
        fault  = ST_RUN;
        is_ret = 1'b0;
        case (op)
          OP_RET: begin
            is_ret = 1'b1;
            nxt    = ip;
          end
          OP_ADD, OP_SUB, OP_CMP: begin
            if (d < 2) begin
              fault = ST_UNDER;
            end else begin
              second = stack_words[d-2];
              top    = stack_words[d-1];
              if (op == OP_ADD) res = second + top;
              else if (op == OP_SUB) res = top - second;
              else if ($signed(second) < $signed(top)) res = WORD_W'(1);
              else if ($signed(second) > $signed(top)) res = '1;
              else res = '0;
              stack_words[d-2] = res;
              depth = d - 1;
            end
          end
          OP_LD: begin
            if (sarg < 0 || sarg >= MEM_DEPTH_DEF) begin
              fault = ST_BADADDR;
            end else if (d >= STACK_DEPTH_DEF) begin
              fault = ST_OVER;
            end else begin
              stack_words[d] = data_words[int'(sarg)];
              depth = d + 1;
            end
          end
          OP_ST: begin
            if (d == 0) begin
              fault = ST_UNDER;
            end else if (sarg < 0 || sarg >= MEM_DEPTH_DEF) begin
              fault = ST_BADADDR;
            end else begin
              data_words[int'(sarg)] = stack_words[d-1];
              depth = d - 1;
            end
          end
          OP_LDC: begin
            if (d >= STACK_DEPTH_DEF) begin
              fault = ST_OVER;
            end else begin
              stack_words[d] = arg;
              depth = d + 1;
            end
          end
          OP_JMP: begin
            if (sarg < 0 || sarg > PROG_DEPTH_DEF) fault = ST_BADADDR;
            else nxt = int'(sarg);
          end
          OP_BR: begin
            if (d == 0) begin
              fault = ST_UNDER;
            end else if (stack_words[d-1] != '0) begin
              if (sarg < 0 || sarg > PROG_DEPTH_DEF) fault = ST_BADADDR;
              else nxt = int'(sarg);
            end
          end
          default: nxt = ip;
        endcase
        if (fault != ST_RUN) begin
          halt = fault;
        end else begin
          old = steps;
          if (steps < (1 << STEP_W) - 1) steps++;
          ip = nxt;
          if (is_ret) halt = ST_RET;
          else if (old >= max_steps) halt = ST_LIMIT;
          else if (ip >= plen) halt = ST_END;
        end
      end
      r.ptr    = PTR_OUT_W'(ip);
      r.status = halt;
      r.top    = (depth > 0) ? stack_words[depth-1] : '0;
      r.depth  = DEPTH_OUT_W'(depth);
      expected_steps.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      // keep the log short when the block is badly broken
      if (errors <= 30) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_step(logic [PTR_OUT_W-1:0] ptr, logic [STATUS_W-1:0] st,
                    logic [WORD_W-1:0] top, logic [DEPTH_OUT_W-1:0] dep);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        report_mismatch($sformatf("result with no instruction outstanding: ptr=%0d status=%0d",
                                  ptr, st));
        return;
      end
      want = expected_steps.pop_front();
      checked++;
      if (ptr !== want.ptr || st !== want.status || top !== want.top || dep !== want.depth)
        report_mismatch($sformatf(
          "result %0d: got ptr=%0d status=%0d top=%h depth=%0d, want ptr=%0d %s top=%h depth=%0d",
          checked, ptr, st, top, dep, want.ptr, want.status.name(), want.top, want.depth));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sme_in_if  instr_if();
  sme_out_if step_if();

  stack_machine_executor_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (instr_if),
    .out_o       (step_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  step_scoreboard sb;
  int unsigned    n_sent;
  int unsigned    tx_idle_pct;
  int unsigned    rx_stall_pct;
  ending_e        ending;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(1_000_000);
    $display("** stack_machine_executor_top: FAILED **");
    $finish;
  end

  always @(negedge clk_i) begin
    step_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && step_if.valid && step_if.ready)
      sb.check_step(step_if.next_pointer, step_if.status, step_if.top_value,
                    step_if.stack_depth);
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // half the traffic goes to a few words so loads see earlier stores
  function automatic logic [WORD_W-1:0] pick_addr();
    if ($urandom_range(0, 1)) return $urandom_range(0, 15);
    return $urandom_range(0, MEM_DEPTH_DEF - 1);
  endfunction

  function automatic logic [WORD_W-1:0] bad_mem_addr();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return MEM_DEPTH_DEF;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom_range(MEM_DEPTH_DEF, 32'h7fff_ffff);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] bad_target();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return PROG_DEPTH_DEF + 1;
      2:       return 32'h8000_0000;
      3:       return $urandom() | 32'h8000_0000;
      default: return $urandom_range(PROG_DEPTH_DEF + 1, 32'h7fff_ffff);
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] arith_op();
    case ($urandom_range(0, 2))
      0:       return OP_ADD;
      1:       return OP_SUB;
      default: return OP_CMP;
    endcase
  endfunction

  // called right after a falling edge; returns at the falling edge after the transfer
  task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] arg);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      instr_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    instr_if.valid    <= 1'b1;
    instr_if.opcode   <= op;
    instr_if.argument <= arg;
    do @(posedge clk_i); while (!instr_if.ready);
    sb.note_instr(op, arg);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    instr_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // result register is one stage deep, so the extra wait below covers it
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input int unsigned plen_val, input int unsigned steps_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PROGRAM_LENGTH;
    cfg_data_i  <= CFG_DATA_W'(plen_val);
    @(negedge clk_i);
    cfg_index_i <= CFG_MAX_STEPS;
    cfg_data_i  <= CFG_DATA_W'(steps_val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(CFG_PROGRAM_LENGTH, plen_val);
    sb.set_config(CFG_MAX_STEPS, steps_val);
  endtask

  // jump back before the pointer walks off the end of the program
  task automatic keep_in_bounds();
    if (sb.ip + 1 >= sb.plen) send_instr(OP_JMP, $urandom_range(0, sb.plen - 2));
  endtask

  // a well-formed instruction that keeps the machine running
  task automatic issue_random_instr();
    int unsigned         pick;
    int unsigned         d;
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   arg;
    d    = sb.depth;
    pick = $urandom_range(0, 99);
    arg  = $urandom();
    if (sb.ip + 1 >= sb.plen) begin
      op  = OP_JMP;
      arg = $urandom_range(0, sb.plen - 2);
    end else if (pick < 8) begin
      op = OPCODE_W'($urandom_range(int'(OP_BR) + 1, (1 << OPCODE_W) - 1));
    end else if (pick < 14) begin
      op  = OP_JMP;
      arg = $urandom_range(0, sb.plen - 1);
    end else if (pick < 22 && d >= 1) begin
      op  = OP_BR;
      arg = $urandom_range(0, sb.plen - 1);
    end else if (pick < 50 && d >= 2) begin
      op = arith_op();
    end else if (pick < 62 && d >= 1) begin
      op  = OP_ST;
      arg = pick_addr();
    end else if (pick < 78 && d < 48) begin
      op  = OP_LD;
      arg = pick_addr();
    end else if (d < 48) begin
      op  = OP_LDC;
      arg = pick_word();
    end else begin
      op  = OP_ST;
      arg = pick_addr();
    end
    send_instr(op, arg);
  endtask

  task automatic run_stretch(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 299) == 0) wait_drained();
      issue_random_instr();
    end
  endtask

  task automatic run_directed();
    send_instr(OP_LD, 0);
    send_instr(OP_LD, MEM_DEPTH_DEF - 1);
    send_instr(OP_ADD, $urandom());
    send_instr(OP_LDC, 32'h7fff_ffff);
    send_instr(OP_ADD, $urandom());
    send_instr(OP_LDC, 1);
    send_instr(OP_ADD, $urandom());          // wraps to the most negative word
    send_instr(OP_ST, MEM_DEPTH_DEF - 1);
    send_instr(OP_LD, MEM_DEPTH_DEF - 1);
    send_instr(OP_LDC, 32'h7fff_ffff);
    send_instr(OP_CMP, $urandom());          // second below top
    send_instr(OP_LDC, 32'h8000_0000);
    send_instr(OP_CMP, $urandom());          // second above top
    send_instr(OP_LDC, '1);
    send_instr(OP_CMP, $urandom());          // equal
    send_instr(OP_BR, 0);                    // zero on top, falls through
    send_instr(OP_LDC, 5);
    send_instr(OP_SUB, $urandom());
    send_instr(OP_BR, PROG_DEPTH_DEF - 1);   // taken to the last slot
    send_instr(OP_JMP, 3);
    send_instr(OP_LDC, 0);
    send_instr(OP_SUB, $urandom());          // negative difference
    send_instr(OP_ST, 0);
    send_instr(OPCODE_W'(int'(OP_BR) + 1), $urandom());
    send_instr(OPCODE_W'((1 << OPCODE_W) - 1), $urandom());
  endtask

  task automatic halt_machine(input ending_e how);
    int unsigned kind;
    kind = $urandom_range(0, 3);
    case (how)
      END_RET: send_instr(OP_RET, $urandom());
      END_UNDERFLOW: begin
        // one or no value left for the two-operand ops, none for the others
        kind = $urandom_range(0, 1);
        if (kind == 1 && sb.depth == 0) begin
          keep_in_bounds();
          send_instr(OP_LDC, pick_word());
        end
        while (sb.depth > kind) begin
          keep_in_bounds();
          send_instr(OP_ST, pick_addr());
        end
        if (kind == 1) begin
          send_instr(arith_op(), $urandom());
        end else begin
          case ($urandom_range(0, 2))
            0:       send_instr(arith_op(), $urandom());
            1:       send_instr(OP_BR, $urandom());
            // empty stack wins over a bad address
            default: send_instr(OP_ST, $urandom_range(0, 1) ? bad_mem_addr() : pick_addr());
          endcase
        end
      end
      END_OVERFLOW: begin
        while (sb.depth < STACK_DEPTH_DEF) begin
          keep_in_bounds();
          if ($urandom_range(0, 3) == 0) send_instr(OP_LD, pick_addr());
          else send_instr(OP_LDC, pick_word());
        end
        case (kind)
          0:       send_instr(OP_LDC, pick_word());
          1:       send_instr(OP_LD, pick_addr());
          // address is checked before the full stack
          default: send_instr(OP_LD, bad_mem_addr());
        endcase
      end
      END_BAD_ADDRESS: begin
        case (kind)
          0: send_instr(OP_LD, bad_mem_addr());
          1: begin
            if (sb.depth == 0) begin
              keep_in_bounds();
              send_instr(OP_LDC, pick_word());
            end
            send_instr(OP_ST, bad_mem_addr());
          end
          2: send_instr(OP_JMP, bad_target());
          default: begin
            keep_in_bounds();
            send_instr(OP_LDC, $urandom() | 32'h1);
            send_instr(OP_BR, bad_target());
          end
        endcase
      end
      END_STEP_LIMIT: begin
        wait_drained();
        write_config(sb.plen, $urandom_range(0, 1) ? 1 : sb.steps);
        issue_random_instr();
      end
      END_CUT_PROGRAM: begin
        wait_drained();
        write_config($urandom_range(0, 1) ? 0 : $urandom_range(0, sb.ip), sb.max_steps);
        send_instr(OP_LDC, pick_word());
      end
      default: begin
        if (kind[0]) begin
          send_instr(OP_JMP, kind[1] ? sb.plen : PROG_DEPTH_DEF);
        end else begin
          send_instr(OP_JMP, sb.plen - 1);
          send_instr(OP_LDC, pick_word());
        end
      end
    endcase
  endtask

  initial begin
    sb                = new();
    n_sent            = 0;
    tx_idle_pct       = 18;
    rx_stall_pct      = 78;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CFG_PROGRAM_LENGTH;
    cfg_data_i        = '0;
    instr_if.valid    = 1'b0;
    instr_if.opcode   = OP_RET;
    instr_if.argument = '0;
    step_if.ready     = 1'b0;
    ending            = ending_e'($urandom_range(0, int'(END_RUN_OFF)));
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    // data memory clears after reset with the instruction port held off
    do @(negedge clk_i); while (!instr_if.ready);
    write_config(PROG_DEPTH_DEF, (1 << STEP_W) - 1);

    run_directed();
    run_stretch(500);

    send_instr(OP_JMP, $urandom_range(0, 7));
    wait_drained();
    write_config($urandom_range(64, PROG_DEPTH_DEF - 1),
                 $urandom_range(sb.steps + 8000, (1 << STEP_W) - 1));
    tx_idle_pct  = 78;
    rx_stall_pct = 18;
    run_stretch(530);

    send_instr(OP_JMP, $urandom_range(0, 7));
    wait_drained();
    write_config($urandom_range(16, 80), $urandom_range(sb.steps + 8000, (1 << STEP_W) - 1));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_stretch(530);

    halt_machine(ending);
    // once halted, nothing may change any more
    repeat (12) send_instr(OPCODE_W'($urandom_range(0, (1 << OPCODE_W) - 1)), $urandom());
    wait_drained();

    $display("%0d instructions sent and %0d results checked across stall, idle and free-run phases",
             n_sent, sb.checked);
    $display("machine stopped via %s with status %s after %0d counted steps",
             ending.name(), sb.halt.name(), sb.steps);
    if (sb.errors == 0) begin
      $display("** stack_machine_executor_top: PASSED **");
    end else begin
      $display("** stack_machine_executor_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- stack_machine_executor_top.f -----
hdl/sme_pkg.sv
hdl/sme_if.sv
hdl/sme_stack.sv
hdl/sme_dmem.sv
hdl/stack_machine_executor_top.sv
tb/testbench.sv
